// ===== rtl/qrb_pkg.sv =====
// Shared types and constants for the per-queue packet ring buffer.
package qrb_pkg;

  localparam int HANDLE_BITS = 32;
  localparam int QUEUE_BITS  = 3;
  localparam int CFG_BITS    = 7;
  localparam int COUNT_BITS  = 32;

  localparam logic [CFG_BITS-1:0] CFG_LAST_RESET = 7'd127;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // Slave tuser: action, queue_index. Master tuser: handle_valid, dropped.
  localparam int S_USER_BITS = 1 + QUEUE_BITS;
  localparam int M_USER_BITS = 2;
  localparam int S_DATA_BITS = HANDLE_BITS;
  localparam int M_DATA_BITS = HANDLE_BITS + COUNT_BITS;

  typedef struct packed {
    logic                  handle_valid;
    logic                  dropped;
    logic [COUNT_BITS-1:0] drop_total;
  } qrb_result_t;

endpackage

// ===== rtl/qrb_slot_ram.sv =====
// Synchronous single-port slot memory holding the packet handles of all rings.
module qrb_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic                             re,
  input  logic [AW-1:0]                    addr,
  input  logic [qrb_pkg::HANDLE_BITS-1:0]  wdata,
  output logic [qrb_pkg::HANDLE_BITS-1:0]  rdata
);

  logic [qrb_pkg::HANDLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/qrb_ctrl.sv =====
// Ring pointer, drop counter and wrap-limit control for all queues.
module qrb_ctrl #(
  parameter int NUM_QUEUES      = 8,
  parameter int SLOTS_PER_QUEUE = 128,
  parameter int AW              = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qrb_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic                              req,
  input  logic                              action,
  input  logic [qrb_pkg::QUEUE_BITS-1:0]    queue_index,
  input  logic [qrb_pkg::HANDLE_BITS-1:0]   packet_handle,
  output logic                              mem_we,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_addr,
  output logic [qrb_pkg::HANDLE_BITS-1:0]   mem_wdata,
  output qrb_pkg::qrb_result_t              result
);

  localparam int PW       = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int QAW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LAST_MAX = SLOTS_PER_QUEUE - 1;

  logic [qrb_pkg::CFG_BITS-1:0]   last_slot;
  logic [PW-1:0]                  head [NUM_QUEUES];
  logic [PW-1:0]                  tail [NUM_QUEUES];
  logic [qrb_pkg::COUNT_BITS-1:0] drops [NUM_QUEUES];

  logic [QAW-1:0]                 qsel;
  logic                           in_range;
  logic [PW-1:0]                  limit;
  logic [PW-1:0]                  cur_head;
  logic [PW-1:0]                  cur_tail;
  logic [PW-1:0]                  head_next;
  logic [PW-1:0]                  tail_next;
  logic [qrb_pkg::COUNT_BITS-1:0] drops_next;
  logic                           push_ok;
  logic                           push_drop;
  logic                           pull_hit;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                            input logic [PW-1:0] lim);
    logic [PW-1:0] res;
    if (ptr == lim || (int'(ptr) + 1 >= SLOTS_PER_QUEUE)) begin
      res = '0;
    end else begin
      res = ptr + PW'(1);
    end
    return res;
  endfunction

  always_comb begin
    qsel     = QAW'(queue_index);
    in_range = (int'(queue_index) < NUM_QUEUES);
    if (int'(last_slot) > LAST_MAX) begin
      limit = PW'(LAST_MAX);
    end else begin
      limit = PW'(last_slot);
    end
    cur_head  = head[qsel];
    cur_tail  = tail[qsel];
    tail_next = advance(cur_tail, limit);
    head_next = advance(cur_head, limit);

    // One slot always stays empty, so a full ring is tail+1 == head.
    push_ok   = in_range && (action == qrb_pkg::ACT_PUSH) && (tail_next != cur_head);
    push_drop = in_range && (action == qrb_pkg::ACT_PUSH) && (tail_next == cur_head);
    pull_hit  = in_range && (action == qrb_pkg::ACT_PULL) && (cur_head != cur_tail);

    drops_next = drops[qsel] + qrb_pkg::COUNT_BITS'(1);

    mem_we    = req && push_ok;
    mem_re    = req && pull_hit;
    mem_wdata = packet_handle;
    if (action == qrb_pkg::ACT_PUSH) begin
      mem_addr = AW'(int'(qsel) * SLOTS_PER_QUEUE + int'(cur_tail));
    end else begin
      mem_addr = AW'(int'(qsel) * SLOTS_PER_QUEUE + int'(cur_head));
    end

    result.handle_valid = pull_hit;
    result.dropped      = push_drop;
    if (!in_range) begin
      result.drop_total = '0;
    end else if (push_drop) begin
      result.drop_total = drops_next;
    end else begin
      result.drop_total = drops[qsel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot <= qrb_pkg::CFG_LAST_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        drops[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        last_slot <= cfg_wdata;
      end
      if (req) begin
        if (push_ok) begin
          tail[qsel] <= tail_next;
        end
        if (push_drop) begin
          drops[qsel] <= drops_next;
        end
        if (pull_hit) begin
          head[qsel] <= head_next;
        end
      end
    end
  end

endmodule

// ===== rtl/per_queue_ring_buffer_with_drops.sv =====
// An accepted word passes the read stage and then the output register before it is offered on the master side.
// Throughput: one word per cycle while the master side takes words; pointers update at the accept edge and the slot
// memory is written or read in that same edge, so back-to-back words need no stall.
// The input stalls only while both the read stage and the output register hold words and m_axis_tready is low.
// Reset clears all ring pointers and drop counters and sets the last slot index to 127;
// the slot memory is not cleared and no clearing pass is needed.
module per_queue_ring_buffer_with_drops #(
  parameter int NUM_QUEUES      = 8,
  parameter int SLOTS_PER_QUEUE = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qrb_pkg::CFG_BITS-1:0]      cfg_wdata,    // last_slot_index
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [qrb_pkg::S_DATA_BITS-1:0]   s_axis_tdata, // packet_handle
  input  logic [qrb_pkg::S_USER_BITS-1:0]   s_axis_tuser, // action, queue_index
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [qrb_pkg::M_DATA_BITS-1:0]   m_axis_tdata, // handle_out, drop_total
  output logic [qrb_pkg::M_USER_BITS-1:0]   m_axis_tuser  // handle_valid, dropped
);

  localparam int DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                            accept;
  logic                            mem_we;
  logic                            mem_re;
  logic [AW-1:0]                   mem_addr;
  logic [qrb_pkg::HANDLE_BITS-1:0] mem_wdata;
  logic [qrb_pkg::HANDLE_BITS-1:0] mem_rdata;
  qrb_pkg::qrb_result_t            result;

  logic                            rd_valid;
  qrb_pkg::qrb_result_t            rd_result;
  logic                            rd_move;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_move       = rd_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !(rd_valid && m_axis_tvalid && !m_axis_tready);

  qrb_ctrl #(
    .NUM_QUEUES      (NUM_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
    .AW              (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (accept),
    .action        (s_axis_tuser[0]),
    .queue_index   (s_axis_tuser[qrb_pkg::S_USER_BITS-1:1]),
    .packet_handle (s_axis_tdata),
    .mem_we        (mem_we),
    .mem_re        (mem_re),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .result        (result)
  );

  qrb_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Read stage: the memory data register only changes on an accepted pull, so it
  // holds while this stage waits for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (accept) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
    if (accept) begin
      rd_result <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rd_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (rd_move) begin
      m_axis_tdata <= {rd_result.drop_total,
                       rd_result.handle_valid ? mem_rdata : {qrb_pkg::HANDLE_BITS{1'b0}}};
      m_axis_tuser <= {rd_result.dropped, rd_result.handle_valid};
    end
  end

endmodule

// ===== rtl/qrb_checker.sv =====
// Port-level checks on the ring buffer top level, attached by bind.
module qrb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qrb_pkg::M_DATA_BITS-1:0] m_axis_tdata,
  input logic [qrb_pkg::M_USER_BITS-1:0] m_axis_tuser
);

  // A stalled word keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // A word cannot both return a handle and report a drop.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("handle returned and drop flagged together");

  // Without a returned handle the handle field reads zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[qrb_pkg::HANDLE_BITS-1:0] == '0)
    else $error("handle field not zero on an empty pull or push");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind per_queue_ring_buffer_with_drops qrb_checker u_qrb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
